// ===== rtl/core/rpn_pkg.sv =====
// Shared types, codes and a helper function for the RPN stack calculator.
package rpn_pkg;

   typedef enum logic [2:0] {
      KIND_PUSH    = 3'd0,
      KIND_ADD     = 3'd1,
      KIND_SUB     = 3'd2,
      KIND_MUL     = 3'd3,
      KIND_DIV     = 3'd4,
      KIND_MOD     = 3'd5,
      KIND_PRINT   = 3'd6,
      KIND_UNKNOWN = 3'd7
   } kind_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_POP_R, ST_CAP_R, ST_POP_L, ST_CAP_L, ST_EXEC,
      ST_MUL_FIN, ST_DIV_RUN, ST_DIV_FIN, ST_PUSH, ST_RESP
   } state_type;

   localparam int DIV_BITS = 49;   // dividend width of the shared divider
   localparam int DVS_BITS = 33;   // divisor width

   typedef struct packed {
      kind_type op;
      logic     accept;
      logic     pop;
      logic     cap_r;
      logic     cap_l;
      logic     exec;
      logic     mul_fin;
      logic     div_step;
      logic     div_fin;
      logic     push;
      logic     set_dbz;
   } cmd_type;

   typedef struct packed {
      logic rhs_zero;
      logic div_last;
   } status_type;

   // Saturate a sign and magnitude into signed 32-bit.
   function automatic logic [31:0] pack_sat(input logic neg,
                                            input logic [DIV_BITS-1:0] mag);
      logic [31:0] r;
      if (neg) begin
         if (mag > DIV_BITS'(64'h8000_0000)) r = 32'h8000_0000;
         else                                 r = 32'd0 - mag[31:0];
      end else begin
         if (mag > DIV_BITS'(64'h7FFF_FFFF)) r = 32'h7FFF_FFFF;
         else                                 r = mag[31:0];
      end
      return r;
   endfunction

endpackage

// ===== rtl/core/rpn_stack_calculator.sv =====
// Top level of the RPN stack calculator: controller plus datapath.
// Takes one parsed token per item (push, add, sub, mul, div, mod, print,
// unknown) and returns exactly one result item for it, on signed Q16.16
// values with saturation. The block works on one item at a time: req_ready
// is high only while it is idle, and drops from accept until the result item
// is taken; the result item waits while the receiver holds rsp_ready low. The
// timing of each item is set by the single-port stack memory (one registered
// pop per operand) and the restoring divider, which produces one of its 49
// quotient bits per cycle; a zero divisor ends a divide or modulo early,
// before the second pop. The stack needs no clearing pass: only entries below
// the stack pointer are ever read.
module rpn_stack_calculator #(
   parameter int STACK_DEPTH = 128
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_kind,
   input  logic signed [31:0] req_number_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_printed,
   output logic signed [31:0] rsp_print_value,
   output logic               rsp_stack_overflow,
   output logic               rsp_stack_underflow,
   output logic               rsp_divide_by_zero,
   output logic               rsp_unknown_operation
);
   import rpn_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Sequence pops, arithmetic and the push of each item.
   rpn_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_kind  (req_kind),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Hold the stack, the operands and the result fields.
   rpn_dpath #(.STACK_DEPTH(STACK_DEPTH)) u_dpath (
      .clock                 (clock),
      .reset                 (reset),
      .req_number_value      (req_number_value),
      .cmd                   (cmd),
      .status                (status),
      .rsp_printed           (rsp_printed),
      .rsp_print_value       (rsp_print_value),
      .rsp_stack_overflow    (rsp_stack_overflow),
      .rsp_stack_underflow   (rsp_stack_underflow),
      .rsp_divide_by_zero    (rsp_divide_by_zero),
      .rsp_unknown_operation (rsp_unknown_operation)
   );

   // Never take a new item while a result is pending.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("req_ready high while a result item is pending");

   // An unknown token touches nothing else.
   a_unknown_alone: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_unknown_operation) |->
      !(rsp_printed || rsp_stack_overflow || rsp_stack_underflow ||
        rsp_divide_by_zero))
      else $error("unknown token reported other flags");

   // A zero divisor pushes nothing, so it cannot overflow.
   a_dbz_no_push: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_divide_by_zero) |-> !rsp_stack_overflow)
      else $error("divide by zero together with overflow");

endmodule

// ===== rtl/core/rpn_ctrl.sv =====
// Sequencing state machine of the RPN stack calculator.
module rpn_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [2:0]          req_kind,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  rpn_pkg::status_type status,
   output rpn_pkg::cmd_type    cmd
);
   import rpn_pkg::*;

   state_type state_ff, state_in;
   kind_type  kind_ff, kind_in, kind_cur;
   logic      divmod;

   assign kind_cur = (state_ff == ST_IDLE) ? kind_type'(req_kind) : kind_ff;
   assign divmod   = (kind_ff == KIND_DIV) || (kind_ff == KIND_MOD);
   assign kind_in  = (state_ff == ST_IDLE && req_valid) ? kind_type'(req_kind) : kind_ff;

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               priority case (kind_type'(req_kind))
                  KIND_PUSH:    state_in = ST_PUSH;
                  KIND_UNKNOWN: state_in = ST_RESP;
                  default:      state_in = ST_POP_R;
               endcase
            end
         end
         ST_POP_R: state_in = ST_CAP_R;
         ST_CAP_R: state_in = (kind_ff == KIND_PRINT) ? ST_RESP : ST_POP_L;
         ST_POP_L: state_in = (divmod && status.rhs_zero) ? ST_RESP : ST_CAP_L;
         ST_CAP_L: state_in = ST_EXEC;
         ST_EXEC: begin
            if (divmod)                 state_in = ST_DIV_RUN;
            else if (kind_ff == KIND_MUL) state_in = ST_MUL_FIN;
            else                        state_in = ST_PUSH;
         end
         ST_MUL_FIN: state_in = ST_PUSH;
         ST_DIV_RUN: if (status.div_last) state_in = ST_DIV_FIN;
         ST_DIV_FIN: state_in = ST_PUSH;
         ST_PUSH:    state_in = ST_RESP;
         ST_RESP:    if (rsp_ready) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd          = '0;
      cmd.op       = kind_cur;
      cmd.accept   = (state_ff == ST_IDLE) && req_valid;
      cmd.pop      = (state_ff == ST_POP_R) ||
                     ((state_ff == ST_POP_L) && !(divmod && status.rhs_zero));
      cmd.set_dbz  = (state_ff == ST_POP_L) && divmod && status.rhs_zero;
      cmd.cap_r    = (state_ff == ST_CAP_R);
      cmd.cap_l    = (state_ff == ST_CAP_L);
      cmd.exec     = (state_ff == ST_EXEC);
      cmd.mul_fin  = (state_ff == ST_MUL_FIN);
      cmd.div_step = (state_ff == ST_DIV_RUN);
      cmd.div_fin  = (state_ff == ST_DIV_FIN);
      cmd.push     = (state_ff == ST_PUSH);
      req_ready    = (state_ff == ST_IDLE);
      rsp_valid    = (state_ff == ST_RESP);
   end

endmodule

// ===== rtl/core/rpn_dpath.sv =====
// Operand stack, arithmetic units and result registers of the RPN calculator.
module rpn_dpath #(
   parameter int STACK_DEPTH = 128
) (
   input  logic                clock,
   input  logic                reset,
   input  logic signed [31:0]  req_number_value,
   input  rpn_pkg::cmd_type    cmd,
   output rpn_pkg::status_type status,
   output logic                rsp_printed,
   output logic signed [31:0]  rsp_print_value,
   output logic                rsp_stack_overflow,
   output logic                rsp_stack_underflow,
   output logic                rsp_divide_by_zero,
   output logic                rsp_unknown_operation
);
   import rpn_pkg::*;

   localparam int AW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int SPW = $clog2(STACK_DEPTH + 1);

   logic [31:0] mem [STACK_DEPTH];
   logic [SPW-1:0] sp_ff;
   logic [31:0] rd_ff, r_ff, l_ff, res_ff;
   logic pop_ok_ff;
   logic over_ff, under_ff, dbz_ff, unk_ff, prt_ff;
   logic [63:0] prod_ff;
   logic neg_ff;
   logic [DIV_BITS-1:0] quo_ff;
   logic [DVS_BITS-1:0] dvs_ff, rem_ff;
   logic [5:0] cnt_ff;

   logic [31:0] ma, mb;
   logic [32:0] sum;
   logic [DVS_BITS:0] trial;
   logic [DIV_BITS-1:0] mul_q;
   logic full, empty;

   assign full  = (sp_ff >= SPW'(STACK_DEPTH));
   assign empty = (sp_ff == '0);
   assign ma    = l_ff[31] ? (32'd0 - l_ff) : l_ff;
   assign mb    = r_ff[31] ? (32'd0 - r_ff) : r_ff;
   assign sum   = (cmd.op == KIND_SUB) ? ({l_ff[31], l_ff} - {r_ff[31], r_ff})
                                       : ({l_ff[31], l_ff} + {r_ff[31], r_ff});
   assign trial = {rem_ff, quo_ff[DIV_BITS-1]};
   assign mul_q = DIV_BITS'((prod_ff + 64'h8000) >> 16);

   // Stack memory with registered read.
   always_ff @(posedge clock) begin
      if (cmd.pop && !empty) rd_ff <= mem[AW'(sp_ff - SPW'(1))];
      if (cmd.push && !full) mem[AW'(sp_ff)] <= res_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff <= '0;
      end else begin
         if (cmd.pop && !empty)       sp_ff <= sp_ff - SPW'(1);
         else if (cmd.push && !full)  sp_ff <= sp_ff + SPW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.pop) pop_ok_ff <= !empty;
      if (cmd.cap_r) r_ff <= pop_ok_ff ? rd_ff : 32'd0;
      if (cmd.cap_l) l_ff <= pop_ok_ff ? rd_ff : 32'd0;

      if (cmd.accept) begin
         res_ff   <= req_number_value;
         over_ff  <= 1'b0;
         under_ff <= 1'b0;
         dbz_ff   <= 1'b0;
         unk_ff   <= (cmd.op == KIND_UNKNOWN);
         prt_ff   <= (cmd.op == KIND_PRINT);
      end
      if (cmd.pop && empty)  under_ff <= 1'b1;
      if (cmd.push && full)  over_ff  <= 1'b1;
      if (cmd.set_dbz)       dbz_ff   <= 1'b1;

      if (cmd.exec) begin
         prod_ff <= 64'(ma) * 64'(mb);
         if (cmd.op == KIND_MOD) begin
            neg_ff <= l_ff[31];
            quo_ff <= DIV_BITS'(ma);
            dvs_ff <= DVS_BITS'(mb);
         end else begin
            neg_ff <= l_ff[31] ^ r_ff[31];
            quo_ff <= (DIV_BITS'(ma) << 17) + DIV_BITS'(mb);
            dvs_ff <= {mb, 1'b0};
         end
         rem_ff <= '0;
         cnt_ff <= 6'(DIV_BITS);
         if (sum[32] != sum[31]) res_ff <= sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
         else                    res_ff <= sum[31:0];
      end
      // One quotient bit per cycle, restoring.
      if (cmd.div_step) begin
         cnt_ff <= cnt_ff - 6'd1;
         if (trial >= {1'b0, dvs_ff}) begin
            rem_ff <= DVS_BITS'(trial - {1'b0, dvs_ff});
            quo_ff <= {quo_ff[DIV_BITS-2:0], 1'b1};
         end else begin
            rem_ff <= DVS_BITS'(trial);
            quo_ff <= {quo_ff[DIV_BITS-2:0], 1'b0};
         end
      end
      if (cmd.mul_fin) res_ff <= pack_sat(neg_ff && (mul_q != '0), mul_q);
      if (cmd.div_fin) begin
         if (cmd.op == KIND_MOD)
            res_ff <= pack_sat(neg_ff && (rem_ff != '0), DIV_BITS'(rem_ff));
         else
            res_ff <= pack_sat(neg_ff && (quo_ff != '0), quo_ff);
      end
   end

   assign status.rhs_zero = (r_ff == 32'd0);
   assign status.div_last = (cnt_ff == 6'd1);

   assign rsp_printed           = prt_ff;
   assign rsp_print_value       = prt_ff ? r_ff : 32'sd0;
   assign rsp_stack_overflow    = over_ff;
   assign rsp_stack_underflow   = under_ff;
   assign rsp_divide_by_zero    = dbz_ff;
   assign rsp_unknown_operation = unk_ff;

endmodule

// ===== tb/tb_rpn_stack_calculator.sv =====
// Self-checking testbench for the RPN stack calculator.
`timescale 1ns / 100ps

module tb_rpn_stack_calculator;
   import rpn_pkg::*;

   localparam int DEPTH = 128;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct {
      kind_type    kind;
      logic [31:0] number;
   } token_type;

   typedef struct {
      logic        printed;
      logic [31:0] value;
      logic        overflow;
      logic        underflow;
      logic        dbz;
      logic        unknown;
   } outcome_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [2:0]         req_kind;
   logic signed [31:0] req_number_value;
   logic               rsp_valid;
   logic               rsp_ready;
   logic               rsp_printed;
   logic signed [31:0] rsp_print_value;
   logic               rsp_stack_overflow;
   logic               rsp_stack_underflow;
   logic               rsp_divide_by_zero;
   logic               rsp_unknown_operation;

   rpn_stack_calculator #(.STACK_DEPTH(DEPTH)) dut (.*);

   // Own copy of the operand stack.
   logic [31:0] model_stack [DEPTH];
   int          model_depth;

   token_type   token_queue [$];
   outcome_type outcome_queue [$];

   int  error_count;
   int  sender_idle_pct;
   int  receiver_stall_pct;
   int  hold_off_cycles;
   int  quiet_cycles;

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $time);
      error_count++;
   endtask

   function automatic logic [31:0] saturate(input logic neg, input logic [63:0] mag);
      if (neg) return (mag > 64'h8000_0000) ? 32'h8000_0000 : 32'd0 - mag[31:0];
      return (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
   endfunction

   function automatic logic [63:0] abs64(input logic signed [63:0] x);
      return x < 0 ? -x : x;
   endfunction

   // Work out the expected item for one token and advance the model stack.
   function automatic outcome_type evaluate_token(input token_type t);
      outcome_type o;
      logic [31:0] rhs, lhs;
      logic signed [63:0] a, b;
      logic [63:0] ma, mb, q;
      logic neg;
      o = '{default: 0};
      rhs = 0;
      lhs = 0;
      if (t.kind inside {KIND_ADD, KIND_SUB, KIND_MUL, KIND_DIV, KIND_MOD, KIND_PRINT}) begin
         if (model_depth > 0) rhs = model_stack[--model_depth];
         else o.underflow = 1;
      end
      if (t.kind inside {KIND_DIV, KIND_MOD} && rhs == 0) begin
         o.dbz = 1;
         return o;
      end
      if (t.kind inside {KIND_ADD, KIND_SUB, KIND_MUL, KIND_DIV, KIND_MOD}) begin
         if (model_depth > 0) lhs = model_stack[--model_depth];
         else o.underflow = 1;
      end
      a = $signed(lhs);
      b = $signed(rhs);
      ma = abs64(a);
      mb = abs64(b);
      neg = (a < 0) != (b < 0);
      q = 0;
      case (t.kind)
         KIND_PUSH:    q = t.number;
         KIND_ADD:     q = saturate(a + b < 0, abs64(a + b));
         KIND_SUB:     q = saturate(a - b < 0, abs64(a - b));
         KIND_MUL: begin
            q = (ma * mb + 64'h8000) >> 16;
            q = saturate(neg && q != 0, q);
         end
         KIND_DIV: begin
            q = ((ma << 17) + mb) / (mb << 1);
            q = saturate(neg && q != 0, q);
         end
         KIND_MOD: begin
            q = ma % mb;
            q = saturate(a < 0 && q != 0, q);
         end
         KIND_PRINT: begin
            o.printed = 1;
            o.value = rhs;
         end
         default: o.unknown = 1;
      endcase
      if (!(t.kind inside {KIND_PRINT, KIND_UNKNOWN})) begin
         if (model_depth < DEPTH) model_stack[model_depth++] = q[31:0];
         else o.overflow = 1;
      end
      return o;
   endfunction

   // Driver: offer the head of the queue, hold it until accepted.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            outcome_queue.push_back(evaluate_token(token_queue.pop_front()));
         end
         if (req_valid && !req_ready) begin
            // hold the item
         end else if (token_queue.size() > 0 &&
                      $urandom_range(99) >= sender_idle_pct) begin
            req_valid        <= 1'b1;
            req_kind         <= token_queue[0].kind;
            req_number_value <= token_queue[0].number;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor: compare each accepted result with the oldest expectation.
   always @(posedge clock) begin
      outcome_type exp_o;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (outcome_queue.size() == 0) begin
               report_mismatch("unexpected item", 0, 0);
            end else begin
               exp_o = outcome_queue.pop_front();
               if (rsp_printed !== exp_o.printed)
                  report_mismatch("printed", rsp_printed, exp_o.printed);
               if (rsp_print_value !== exp_o.value)
                  report_mismatch("print_value", rsp_print_value, exp_o.value);
               if (rsp_stack_overflow !== exp_o.overflow)
                  report_mismatch("overflow", rsp_stack_overflow, exp_o.overflow);
               if (rsp_stack_underflow !== exp_o.underflow)
                  report_mismatch("underflow", rsp_stack_underflow, exp_o.underflow);
               if (rsp_divide_by_zero !== exp_o.dbz)
                  report_mismatch("divide_by_zero", rsp_divide_by_zero, exp_o.dbz);
               if (rsp_unknown_operation !== exp_o.unknown)
                  report_mismatch("unknown", rsp_unknown_operation, exp_o.unknown);
            end
         end
         if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= $urandom_range(99) >= receiver_stall_pct;
         end
      end
   end

   // Watchdog: count cycles with no accepted item.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic [31:0] random_number();
      case ($urandom_range(5))
         0:       return $urandom;
         1:       return $urandom_range(8) << 16;
         2:       return -($urandom_range(8) << 16);
         3:       return $urandom_range(3);
         4:       return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
         default: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      endcase
   endfunction

   task automatic add_token(input kind_type k, input logic [31:0] n);
      token_type t;
      t.kind = k;
      t.number = n;
      token_queue.push_back(t);
   endtask

   // Wait until everything queued has gone through the block.
   task automatic drain();
      while (token_queue.size() != 0 || req_valid || outcome_queue.size() != 0)
         @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   // Random items, mostly well formed: push whenever fewer than two operands are expected.
   task automatic random_items(input int count);
      int depth_guess;
      depth_guess = 0;
      repeat (count) begin
         if ($urandom_range(99) < 4) begin
            add_token(kind_type'($urandom_range(7)), $urandom);
         end else if (depth_guess < 2 || $urandom_range(99) < 35) begin
            add_token(KIND_PUSH, random_number());
            depth_guess++;
         end else begin
            add_token(kind_type'($urandom_range(int'(KIND_ADD), int'(KIND_PRINT))),
                      $urandom);
            depth_guess--;
         end
      end
   endtask

   initial begin
      req_valid = 0;
      req_kind = 0;
      req_number_value = 0;
      rsp_ready = 0;
      error_count = 0;
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      hold_off_cycles = 0;
      model_depth = 0;
      reset = 1;
      repeat (5) @(posedge clock);
      reset <= 0;

      // Directed: underflow, dbz, unknown, extremes, saturation, rounding.
      add_token(KIND_ADD, 0);
      add_token(KIND_PRINT, 0);
      add_token(KIND_UNKNOWN, 32'hFFFF_FFFF);
      add_token(KIND_PUSH, 32'h0001_0000);
      add_token(KIND_PUSH, 0);
      add_token(KIND_DIV, 0);
      add_token(KIND_PUSH, 0);
      add_token(KIND_MOD, 0);
      add_token(KIND_PUSH, 32'h7FFF_FFFF);
      add_token(KIND_PUSH, 32'h7FFF_FFFF);
      add_token(KIND_ADD, 0);
      add_token(KIND_PUSH, 32'h8000_0000);
      add_token(KIND_SUB, 0);
      add_token(KIND_PUSH, 32'h8000_0000);
      add_token(KIND_MUL, 0);
      add_token(KIND_PUSH, 32'hFFFF_8000);
      add_token(KIND_PUSH, 32'h0000_0001);
      add_token(KIND_MUL, 0);
      add_token(KIND_PUSH, 32'hFFF9_0000);
      add_token(KIND_PUSH, 32'h0002_0000);
      add_token(KIND_MOD, 0);
      add_token(KIND_PUSH, 32'h0003_0000);
      add_token(KIND_DIV, 0);
      add_token(KIND_PRINT, 0);
      add_token(KIND_PRINT, 0);
      drain();

      // Fill the stack past full, then empty it.
      for (int i = 0; i < DEPTH + 2; i++) add_token(KIND_PUSH, $urandom);
      for (int i = 0; i < DEPTH + 1; i++) add_token(KIND_PRINT, 0);
      drain();

      random_items(190);
      drain();

      sender_idle_pct = 45;
      random_items(190);
      drain();

      sender_idle_pct = 0;
      receiver_stall_pct = 45;
      random_items(190);
      // Long receiver hold-off while the sender keeps offering.
      hold_off_cycles = 300;
      drain();

      sender_idle_pct = 33;
      receiver_stall_pct = 33;
      random_items(190);
      drain();

      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/rpn_pkg.sv
rtl/core/rpn_ctrl.sv
rtl/core/rpn_dpath.sv
rtl/core/rpn_stack_calculator.sv
tb/tb_rpn_stack_calculator.sv
